>>> design/rrpp_pkg.sv
package rrpp_pkg;

    localparam int MAX_PER_SIDE = 10000;
    localparam int CNT_W        = $clog2(MAX_PER_SIDE + 1);
    localparam int IDX_W        = 16;
    localparam int FRAC_W       = 16;
    localparam int DIV_STAGES   = FRAC_W / 2;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_CENTER_X = 3'd0;
    localparam reg_idx_t REG_CENTER_Y = 3'd1;
    localparam reg_idx_t REG_WIDTH    = 3'd2;
    localparam reg_idx_t REG_HEIGHT   = 3'd3;
    localparam reg_idx_t REG_COS      = 3'd4;
    localparam reg_idx_t REG_SIN      = 3'd5;
    localparam reg_idx_t REG_SPACING  = 3'd6;
    localparam reg_idx_t REG_OUTWARD  = 3'd7;

    typedef enum logic [1:0] {
        SIDE_LEFT,
        SIDE_TOP,
        SIDE_RIGHT,
        SIDE_BOTTOM
    } side_t;

    typedef enum logic [2:0] {
        CFG_IDLE,
        CFG_LOAD_W,
        CFG_DIV_W,
        CFG_LOAD_H,
        CFG_DIV_H,
        CFG_SUMS
    } cfg_state_t;

    // per-item bookkeeping that rides along the pipeline
    typedef struct packed {
        side_t              side;
        logic               oor;
        logic               last;
        logic [IDX_W-1:0]   first;
        logic [IDX_W-1:0]   second;
    } tag_t;

    typedef struct packed {
        tag_t               tag;
        logic [CNT_W-1:0]   n;
        logic [CNT_W-1:0]   rem;
        logic [FRAC_W-1:0]  q;
    } div_t;

endpackage

>>> design/rotated_rectangle_perimeter_points.sv
// Rotated rectangle perimeter point generator. Each item on the s_ channel is a
// point index k; the m_ channel returns that boundary point (Q16.16, rotated by
// the programmed Q1.14 cos/sin about the center and translated to it), the two
// endpoint indices of the panel starting at k (last panel closes to 0, swapped
// when outward is 0), the total panel count and last/out-of-range flags. An
// index not below the total gives out_of_range with all other fields zero.
// Throughput is one item per clock unless m_ready stalls the output or the
// side counts are being recomputed; items pass the entry register, the 8-stage
// fraction divider (two quotient bits per stage), two multiplier stages and
// the output register. Writing width, height or spacing starts a shared
// bit-serial divider that recomputes the side counts (two 32-bit divisions plus
// load and sum steps); s_ready is low until it ends.
module rotated_rectangle_perimeter_points
    import rrpp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IDX_W-1:0]     s_point_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_point_x,
    output logic signed [31:0]   m_point_y,
    output logic [IDX_W-1:0]     m_panel_first,
    output logic [IDX_W-1:0]     m_panel_second,
    output logic [IDX_W-1:0]     m_total_panels,
    output logic                 m_is_last,
    output logic                 m_out_of_range,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  reg_idx_t             cfg_index,
    input  logic [31:0]          cfg_data
);

    // configuration registers
    logic signed [31:0] center_x_reg, center_y_reg;
    logic [31:0]        width_reg, height_reg, spacing_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic               outward_reg;

    // derived side counts and walk boundaries
    logic [CNT_W-1:0]   nx_reg, nx_next, ny_reg, ny_next;
    logic [IDX_W-1:0]   bnd1_reg, bnd2_reg, bnd3_reg, total_reg;
    logic [IDX_W-1:0]   bnd1_next, bnd2_next, bnd3_next, total_next;

    // shared bit-serial divider for the side counts
    cfg_state_t         state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [32:0]        rem_reg, rem_next;
    logic [31:0]        dvd_reg, dvd_next, quo_reg, quo_next;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [31:0]        quo_step;
    logic               cfg_we, dims_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;
    assign dims_we   = cfg_we & ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT)
                                 || (cfg_index == REG_SPACING));

    function automatic logic [CNT_W-1:0] clamp_count(input logic [31:0] q,
                                                     input logic [31:0] sp);
        logic [CNT_W-1:0] r;
        begin
            if (sp == 32'd0) begin
                r = CNT_W'(MAX_PER_SIDE);
            end else if (q == 32'd0) begin
                r = CNT_W'(1);
            end else if (q > 32'(MAX_PER_SIDE)) begin
                r = CNT_W'(MAX_PER_SIDE);
            end else begin
                r = q[CNT_W-1:0];
            end
            return r;
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            width_reg    <= 32'd65536;
            height_reg   <= 32'd65536;
            cos_reg      <= 16'sd16384;
            sin_reg      <= '0;
            spacing_reg  <= 32'd65536;
            outward_reg  <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_WIDTH:    width_reg    <= cfg_data;
                REG_HEIGHT:   height_reg   <= cfg_data;
                REG_COS:      cos_reg      <= cfg_data[15:0];
                REG_SIN:      sin_reg      <= cfg_data[15:0];
                REG_SPACING:  spacing_reg  <= cfg_data;
                REG_OUTWARD:  outward_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CFG_IDLE;
            nx_reg    <= CNT_W'(1);
            ny_reg    <= CNT_W'(1);
            bnd1_reg  <= IDX_W'(1);
            bnd2_reg  <= IDX_W'(2);
            bnd3_reg  <= IDX_W'(3);
            total_reg <= IDX_W'(4);
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            bnd1_reg  <= bnd1_next;
            bnd2_reg  <= bnd2_next;
            bnd3_reg  <= bnd3_next;
            total_reg <= total_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    // one restoring step: shift in a dividend bit, subtract if it fits
    assign rem_sh   = {rem_reg[31:0], dvd_reg[31]};
    assign rem_ge   = rem_sh >= {1'b0, spacing_reg};
    assign quo_step = {quo_reg[30:0], rem_ge};

    always_comb begin
        state_next = state_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        bnd1_next  = bnd1_reg;
        bnd2_next  = bnd2_reg;
        bnd3_next  = bnd3_reg;
        total_next = total_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        case (state_reg)
            CFG_IDLE: ;
            CFG_LOAD_W, CFG_LOAD_H: begin
                dvd_next   = (state_reg == CFG_LOAD_W) ? width_reg : height_reg;
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = (state_reg == CFG_LOAD_W) ? CFG_DIV_W : CFG_DIV_H;
            end
            CFG_DIV_W, CFG_DIV_H: begin
                rem_next = rem_ge ? (rem_sh - {1'b0, spacing_reg}) : rem_sh;
                dvd_next = {dvd_reg[30:0], 1'b0};
                quo_next = quo_step;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    if (state_reg == CFG_DIV_W) begin
                        nx_next    = clamp_count(quo_step, spacing_reg);
                        state_next = CFG_LOAD_H;
                    end else begin
                        ny_next    = clamp_count(quo_step, spacing_reg);
                        state_next = CFG_SUMS;
                    end
                end
            end
            CFG_SUMS: begin
                bnd1_next  = IDX_W'(ny_reg);
                bnd2_next  = IDX_W'(ny_reg) + IDX_W'(nx_reg);
                bnd3_next  = IDX_W'({ny_reg, 1'b0}) + IDX_W'(nx_reg);
                total_next = IDX_W'({ny_reg, 1'b0}) + IDX_W'({nx_reg, 1'b0});
                state_next = CFG_IDLE;
            end
            default: state_next = CFG_IDLE;
        endcase
        // a new dimension or spacing restarts the count computation
        if (dims_we) begin
            state_next = CFG_LOAD_W;
        end
    end

    // ---------------- item pipeline ----------------
    // whole pipe moves together whenever the output register can drain
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv && (state_reg == CFG_IDLE);

    // entry stage: side select, local index, panel ends
    logic             e_vld_reg;
    tag_t             e_tag_reg;
    logic [CNT_W-1:0] e_i_reg, e_n_reg;
    tag_t             e_tag_next;
    logic [CNT_W-1:0] e_i_next, e_n_next;
    logic [IDX_W-1:0] k, k_plus;
    logic [IDX_W-1:0] k_off, pf, ps;

    assign k      = s_point_index;
    assign k_plus = k + IDX_W'(1);

    always_comb begin
        e_tag_next.oor  = k >= total_reg;
        e_tag_next.last = k_plus == total_reg;
        if (k < bnd1_reg) begin
            e_tag_next.side = SIDE_LEFT;
            k_off           = k;
            e_n_next        = ny_reg;
        end else if (k < bnd2_reg) begin
            e_tag_next.side = SIDE_TOP;
            k_off           = k - bnd1_reg;
            e_n_next        = nx_reg;
        end else if (k < bnd3_reg) begin
            e_tag_next.side = SIDE_RIGHT;
            k_off           = k - bnd2_reg;
            e_n_next        = ny_reg;
        end else begin
            e_tag_next.side = SIDE_BOTTOM;
            k_off           = k - bnd3_reg;
            e_n_next        = nx_reg;
        end
        e_i_next = k_off[CNT_W-1:0];
        pf       = k;
        ps       = e_tag_next.last ? '0 : k_plus;
        // holes walk each panel the other way
        e_tag_next.first  = outward_reg ? pf : ps;
        e_tag_next.second = outward_reg ? ps : pf;
    end

    // fraction divider: s = floor(i * 2^16 / n), two quotient bits per stage
    logic [DIV_STAGES-1:0] d_vld_reg;
    div_t                  d_reg  [DIV_STAGES];
    div_t                  d_in   [DIV_STAGES];
    div_t                  d_next [DIV_STAGES];

    function automatic logic [CNT_W:0] frac_step(input logic [CNT_W-1:0] rem,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W:0] sh;
        logic           ge;
        begin
            sh = {rem, 1'b0};
            ge = sh >= {1'b0, n};
            if (ge) begin
                sh = sh - {1'b0, n};
            end
            return {sh[CNT_W-1:0], ge};
        end
    endfunction

    always_comb begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            logic [CNT_W:0] r1, r2;
            if (j == 0) begin
                d_in[j].tag = e_tag_reg;
                d_in[j].n   = e_n_reg;
                d_in[j].rem = e_i_reg;
                d_in[j].q   = '0;
            end else begin
                d_in[j] = d_reg[j-1];
            end
            r1 = frac_step(d_in[j].rem, d_in[j].n);
            r2 = frac_step(r1[CNT_W:1], d_in[j].n);
            d_next[j]     = d_in[j];
            d_next[j].rem = r2[CNT_W:1];
            d_next[j].q   = {d_in[j].q[FRAC_W-3:0], r1[0], r2[0]};
        end
    end

    // first multiply: local offsets px, py
    logic               m1_vld_reg;
    tag_t               m1_tag_reg;
    logic signed [32:0] px_reg, py_reg;
    logic signed [17:0] s_sig, fx, fy;
    logic signed [50:0] px_prod, py_prod;
    div_t               d_last;

    assign d_last = d_reg[DIV_STAGES-1];
    assign s_sig  = $signed({2'b00, d_last.q});

    always_comb begin
        case (d_last.tag.side)
            SIDE_LEFT: begin
                fx = -18'sd32768;
                fy = s_sig - 18'sd32768;
            end
            SIDE_TOP: begin
                fx = s_sig - 18'sd32768;
                fy = 18'sd32768;
            end
            SIDE_RIGHT: begin
                fx = 18'sd32768;
                fy = 18'sd32768 - s_sig;
            end
            default: begin
                fx = 18'sd32768 - s_sig;
                fy = -18'sd32768;
            end
        endcase
    end

    assign px_prod = $signed({1'b0, width_reg}) * fx;
    assign py_prod = $signed({1'b0, height_reg}) * fy;

    // second multiply: rotation products
    logic               m2_vld_reg;
    tag_t               m2_tag_reg;
    logic signed [48:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;

    // output register
    logic signed [49:0] rx_sum, ry_sum;
    logic               o_vld_reg;
    tag_t               o_tag_reg;
    logic signed [31:0] o_x_reg, o_y_reg;

    assign rx_sum = pxc_reg - pys_reg;
    assign ry_sum = pxs_reg + pyc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg  <= 1'b0;
            d_vld_reg  <= '0;
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end else if (adv) begin
            e_vld_reg  <= s_valid && s_ready;
            d_vld_reg  <= {d_vld_reg[DIV_STAGES-2:0], e_vld_reg};
            m1_vld_reg <= d_vld_reg[DIV_STAGES-1];
            m2_vld_reg <= m1_vld_reg;
            o_vld_reg  <= m2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_tag_reg  <= e_tag_next;
            e_i_reg    <= e_i_next;
            e_n_reg    <= e_n_next;
            for (int j = 0; j < DIV_STAGES; j++) begin
                d_reg[j] <= d_next[j];
            end
            m1_tag_reg <= d_last.tag;
            px_reg     <= px_prod[48:16];
            py_reg     <= py_prod[48:16];
            m2_tag_reg <= m1_tag_reg;
            pxc_reg    <= px_reg * cos_reg;
            pys_reg    <= py_reg * sin_reg;
            pxs_reg    <= px_reg * sin_reg;
            pyc_reg    <= py_reg * cos_reg;
            o_tag_reg  <= m2_tag_reg;
            o_x_reg    <= center_x_reg + rx_sum[45:14];
            o_y_reg    <= center_y_reg + ry_sum[45:14];
        end
    end

    // out-of-range items show zeros everywhere but the flag
    assign m_valid        = o_vld_reg;
    assign m_out_of_range = o_tag_reg.oor;
    assign m_point_x      = o_tag_reg.oor ? '0 : o_x_reg;
    assign m_point_y      = o_tag_reg.oor ? '0 : o_y_reg;
    assign m_panel_first  = o_tag_reg.oor ? '0 : o_tag_reg.first;
    assign m_panel_second = o_tag_reg.oor ? '0 : o_tag_reg.second;
    assign m_total_panels = o_tag_reg.oor ? '0 : total_reg;
    assign m_is_last      = o_tag_reg.oor ? 1'b0 : o_tag_reg.last;

endmodule

>>> design/rrpp_checker.sv
module rrpp_checker
    import rrpp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic signed [31:0]   m_point_x,
    input logic signed [31:0]   m_point_y,
    input logic [IDX_W-1:0]     m_panel_first,
    input logic [IDX_W-1:0]     m_panel_second,
    input logic [IDX_W-1:0]     m_total_panels,
    input logic                 m_is_last,
    input logic                 m_out_of_range
);

    // out-of-range items carry nothing else
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_point_x == 0 && m_point_y == 0
            && m_panel_first == 0 && m_panel_second == 0 && m_total_panels == 0 && !m_is_last)
        else $error("out-of-range item has nonzero fields");

    // panel ends of a valid point lie below the total
    a_ends_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_of_range |-> m_total_panels >= 16'd4
            && m_panel_first < m_total_panels && m_panel_second < m_total_panels)
        else $error("panel end beyond total");

    // the closing panel has index 0 at one end
    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_last |-> m_panel_first == 0 || m_panel_second == 0)
        else $error("last panel does not close to index 0");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_x) && $stable(m_panel_first))
        else $error("stalled item changed");

endmodule

bind rotated_rectangle_perimeter_points rrpp_checker u_rrpp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_point_x      (m_point_x),
    .m_point_y      (m_point_y),
    .m_panel_first  (m_panel_first),
    .m_panel_second (m_panel_second),
    .m_total_panels (m_total_panels),
    .m_is_last      (m_is_last),
    .m_out_of_range (m_out_of_range)
);
